[rtl/asp_pkg.sv]
`timescale 1ns / 1ps

package asp_pkg;

    localparam int MAX_SLABS_DEF = 64;
    localparam int COORD_W       = 15;
    localparam int CFG_W         = 7;
    localparam int INDEX_W       = 6;
    localparam int TOTAL_W       = 7;
    localparam int PADDR_W       = 3;
    localparam int PDATA_W       = 32;

    localparam logic REG_WORK_NODES = 1'b0;
    localparam logic REG_THREADS    = 1'b1;

    typedef struct packed {
        logic [COORD_W-1:0] box_min_x;
        logic [COORD_W-1:0] box_min_y;
        logic [COORD_W-1:0] box_min_z;
        logic [COORD_W-1:0] box_max_x;
        logic [COORD_W-1:0] box_max_y;
        logic [COORD_W-1:0] box_max_z;
    } box_t;

    typedef struct packed {
        logic [INDEX_W-1:0] slab_index;
        logic [TOTAL_W-1:0] slab_total;
        logic [COORD_W-1:0] slab_min_x;
        logic [COORD_W-1:0] slab_min_y;
        logic [COORD_W-1:0] slab_min_z;
        logic [COORD_W-1:0] slab_max_x;
        logic [COORD_W-1:0] slab_max_y;
        logic [COORD_W-1:0] slab_max_z;
        logic               cut_axis;
        logic               empty_res;
        logic               last;
    } slab_t;

endpackage

[rtl/asp_div.sv]
`timescale 1ns / 1ps

module asp_div #(
    parameter int DEND_W = 15,
    parameter int DSOR_W = 7
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DEND_W-1:0] dividend,
    input  logic [DSOR_W-1:0] divisor,
    output logic              done,
    output logic [DEND_W-1:0] quotient,
    output logic [DSOR_W-1:0] remainder
);

    localparam int STEP_W = $clog2(DEND_W + 1);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DEND_W - 1);

    logic              run_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [DEND_W-1:0] quo_reg;
    logic [DSOR_W-1:0] rem_reg;
    logic [DSOR_W-1:0] dsor_reg;

    logic [DSOR_W:0]   trial;
    logic              fits;
    logic [DSOR_W:0]   diff;

    assign trial = {rem_reg, quo_reg[DEND_W-1]};
    assign fits  = trial >= {1'b0, dsor_reg};
    assign diff  = trial - {1'b0, dsor_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg  <= 1'b1;
                step_reg <= '0;
            end
            else if (run_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg  <= dividend;
            rem_reg  <= '0;
            dsor_reg <= divisor;
        end
        else if (run_reg)
        begin
            quo_reg <= {quo_reg[DEND_W-2:0], fits};
            rem_reg <= fits ? diff[DSOR_W-1:0] : trial[DSOR_W-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

[rtl/axis_slab_partitioner_top.sv]
`timescale 1ns / 1ps

// Channel   Handshake              Payload
// command   start, busy            box    (asp_pkg::box_t)
// result    result_valid           result (asp_pkg::slab_t)
// config    psel/penable/pwrite    paddr, pwdata, prdata, pready
//
// From acceptance, an item passes through setup, then the divider when the cut
// extent is split by the worker count (15 bit-serial divider steps), then one
// beat per slab; a y cut that needs no division skips the divider, and an empty partition gives one beat.
// The next start is taken at the edge that takes the last beat.
// Reset clears the sequencer and sets work_nodes 0, threads_per_node 1.
// Result beats leave one per cycle and cannot be held off.
module axis_slab_partitioner_top #(
    parameter int MAX_SLABS = asp_pkg::MAX_SLABS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  asp_pkg::box_t                 box,
    output logic                          busy,
    output logic                          result_valid,
    output asp_pkg::slab_t                result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [asp_pkg::PADDR_W-1:0]   paddr,
    input  logic [asp_pkg::PDATA_W-1:0]   pwdata,
    output logic [asp_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int CW = asp_pkg::COORD_W;
    localparam int GW = asp_pkg::CFG_W;
    localparam int NW = $clog2(MAX_SLABS + 1);
    localparam int PW = 2 * GW;
    localparam logic [PW-1:0] MAX_P = PW'(MAX_SLABS);
    localparam logic [NW-1:0] MAX_N = NW'(MAX_SLABS);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SETUP = 4'b0010,
        ST_DIV   = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    state_t           state_reg, state_next;
    logic [GW-1:0]    nodes_reg;
    logic [GW-1:0]    threads_reg;
    asp_pkg::box_t    box_reg;
    logic             axis_reg, axis_next;
    logic             empty_reg, empty_next;
    logic [NW-1:0]    count_reg, count_next;
    logic [NW-1:0]    idx_reg, idx_next;
    logic [CW-1:0]    base_reg, base_next;
    logic [NW-1:0]    extra_reg, extra_next;
    logic [CW-1:0]    pos_reg, pos_next;
    logic             result_valid_reg, result_valid_next;
    asp_pkg::slab_t   result_reg, result_next;

    logic             cfg_wr;
    logic [GW-1:0]    threads_eff;
    logic [PW-1:0]    prod;
    logic [NW-1:0]    workers;
    logic [CW-1:0]    ey, ez, len;
    logic [CW-1:0]    workers_c;
    logic             cut_z;
    logic             need_div;
    logic             div_start;
    logic             div_done;
    logic [CW-1:0]    div_quo;
    logic [NW-1:0]    div_rem;
    logic [CW-1:0]    step;
    logic [CW-1:0]    hi;
    logic             is_last;

    // configuration
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nodes_reg   <= '0;
            threads_reg <= GW'(1);
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                asp_pkg::REG_WORK_NODES: nodes_reg   <= pwdata[GW-1:0];
                asp_pkg::REG_THREADS:    threads_reg <= pwdata[GW-1:0];
                default:                 nodes_reg   <= nodes_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            asp_pkg::REG_WORK_NODES: prdata = {{(asp_pkg::PDATA_W-GW){1'b0}}, nodes_reg};
            asp_pkg::REG_THREADS:    prdata = {{(asp_pkg::PDATA_W-GW){1'b0}}, threads_reg};
            default:                 prdata = '0;
        endcase
    end

    // worker count and extents
    assign threads_eff = (threads_reg == '0) ? GW'(1) : threads_reg;
    assign prod        = PW'(nodes_reg) * PW'(threads_eff);

    always_comb
    begin
        if (nodes_reg <= GW'(1))
            workers = NW'(1);
        else if (prod > MAX_P)
            workers = MAX_N;
        else
            workers = prod[NW-1:0];
    end

    assign ey = (box_reg.box_max_y > box_reg.box_min_y) ?
                (box_reg.box_max_y - box_reg.box_min_y) : '0;
    assign ez = (box_reg.box_max_z > box_reg.box_min_z) ?
                (box_reg.box_max_z - box_reg.box_min_z) : '0;
    assign workers_c = CW'(workers);
    assign cut_z     = !((ez == CW'(1)) || (ez < workers_c));
    assign len       = cut_z ? ez : ey;
    assign need_div  = cut_z || (ey > workers_c);
    assign div_start = (state_reg == ST_SETUP) && need_div;

    asp_div #(
        .DEND_W (CW),
        .DSOR_W (NW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (len),
        .divisor   (workers),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // slab stepping
    assign step    = base_reg + CW'(idx_reg < extra_reg);
    assign hi      = pos_reg + step;
    assign is_last = (idx_reg + NW'(1)) == count_reg;

    always_comb
    begin
        state_next        = state_reg;
        axis_next         = axis_reg;
        empty_next        = empty_reg;
        count_next        = count_reg;
        idx_next          = idx_reg;
        base_next         = base_reg;
        extra_next        = extra_reg;
        pos_next          = pos_reg;
        result_valid_next = 1'b0;
        result_next       = result_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                    state_next = ST_SETUP;
            end
            ST_SETUP:
            begin
                axis_next  = cut_z;
                idx_next   = '0;
                pos_next   = cut_z ? box_reg.box_min_z : box_reg.box_min_y;
                base_next  = CW'(1);
                extra_next = '0;
                if (cut_z || (ey > workers_c))
                    count_next = workers;
                else
                    count_next = ey[NW-1:0];
                empty_next = !cut_z && (ey == '0);
                state_next = need_div ? ST_DIV : ST_EMIT;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    base_next  = div_quo;
                    extra_next = div_rem;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                result_valid_next = 1'b1;
                if (empty_reg)
                begin
                    result_next           = '0;
                    result_next.empty_res = 1'b1;
                    result_next.last      = 1'b1;
                    state_next            = ST_IDLE;
                end
                else
                begin
                    result_next.slab_index = asp_pkg::INDEX_W'(idx_reg);
                    result_next.slab_total = asp_pkg::TOTAL_W'(count_reg);
                    result_next.slab_min_x = box_reg.box_min_x;
                    result_next.slab_max_x = box_reg.box_max_x;
                    result_next.slab_min_y = axis_reg ? box_reg.box_min_y : pos_reg;
                    result_next.slab_max_y = axis_reg ? box_reg.box_max_y : hi;
                    result_next.slab_min_z = axis_reg ? pos_reg : box_reg.box_min_z;
                    result_next.slab_max_z = axis_reg ? hi : box_reg.box_max_z;
                    result_next.cut_axis   = axis_reg;
                    result_next.empty_res  = 1'b0;
                    result_next.last       = is_last;
                    pos_next               = hi;
                    idx_next               = idx_reg + NW'(1);
                    if (is_last)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_IDLE) && start)
            box_reg <= box;
        axis_reg   <= axis_next;
        empty_reg  <= empty_next;
        count_reg  <= count_next;
        idx_reg    <= idx_next;
        base_reg   <= base_next;
        extra_reg  <= extra_next;
        pos_reg    <= pos_next;
        result_reg <= result_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

[tb/axis_slab_partitioner_top_tb.sv]
`timescale 1ns / 1ps

module axis_slab_partitioner_top_tb;

    localparam int WORKER_CAP   = asp_pkg::MAX_SLABS_DEF;
    localparam int QUIET_LIMIT  = 3000;
    localparam int SETTLE_TICKS = 100;
    localparam int PHASES       = 9;

    logic                        clk     = 1'b0;
    logic                        rst_n   = 1'b0;
    logic                        start   = 1'b0;
    asp_pkg::box_t               box     = '0;
    logic                        busy;
    logic                        result_valid;
    asp_pkg::slab_t              result;
    logic                        psel    = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite  = 1'b0;
    logic [asp_pkg::PADDR_W-1:0] paddr   = '0;
    logic [asp_pkg::PDATA_W-1:0] pwdata  = '0;
    logic [asp_pkg::PDATA_W-1:0] prdata;
    logic                        pready;

    asp_pkg::box_t  box_backlog[$];
    asp_pkg::slab_t slabs_due[$];
    logic [6:0]  cfg_nodes   = 7'd0;
    logic [6:0]  cfg_threads = 7'd1;
    bit          free_run    = 1'b0;
    int          mismatches  = 0;
    int          boxes_sent  = 0;
    int          beats_seen  = 0;
    int          settings    = 1;
    int          quiet       = 0;

    axis_slab_partitioner_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .box          (box),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int span(logic [asp_pkg::COORD_W-1:0] lo,
                                logic [asp_pkg::COORD_W-1:0] hi);
        return (hi > lo) ? int'(hi) - int'(lo) : 0;
    endfunction

    function automatic int workers();
        int t;
        int w;
        t = (cfg_threads == 0) ? 1 : int'(cfg_threads);
        if (cfg_nodes <= 1)
            return 1;
        w = int'(cfg_nodes) * t;
        return (w > WORKER_CAP) ? WORKER_CAP : w;
    endfunction

    function automatic void add_due(asp_pkg::slab_t s);
        slabs_due.insert(slabs_due.size(), s);
    endfunction

    function automatic void enqueue_box(asp_pkg::box_t b);
        box_backlog.insert(box_backlog.size(), b);
    endfunction

    function automatic void plan_slabs(asp_pkg::box_t b);
        int    w;
        int    ey;
        int    ez;
        int    cnt;
        int    base;
        int    extra;
        int    pos;
        int    stride;
        bit    on_z;
        asp_pkg::slab_t s;
        w  = workers();
        ey = span(b.box_min_y, b.box_max_y);
        ez = span(b.box_min_z, b.box_max_z);
        if (ez == 1 || ez < w)
        begin
            on_z = 1'b0;
            if (ey > w)
            begin
                cnt   = w;
                base  = ey / w;
                extra = ey % w;
            end
            else
            begin
                cnt   = ey;
                base  = 1;
                extra = 0;
            end
        end
        else
        begin
            on_z  = 1'b1;
            cnt   = w;
            base  = ez / w;
            extra = ez % w;
        end
        s = '0;
        if (cnt == 0)
        begin
            s.empty_res = 1'b1;
            s.last      = 1'b1;
            add_due(s);
            return;
        end
        pos = on_z ? int'(b.box_min_z) : int'(b.box_min_y);
        for (int i = 0; i < cnt; i++)
        begin
            stride       = base + ((i < extra) ? 1 : 0);
            s.slab_index = asp_pkg::INDEX_W'(i);
            s.slab_total = asp_pkg::TOTAL_W'(cnt);
            s.slab_min_x = b.box_min_x;
            s.slab_min_y = b.box_min_y;
            s.slab_min_z = b.box_min_z;
            s.slab_max_x = b.box_max_x;
            s.slab_max_y = b.box_max_y;
            s.slab_max_z = b.box_max_z;
            if (on_z)
            begin
                s.slab_min_z = asp_pkg::COORD_W'(pos);
                s.slab_max_z = asp_pkg::COORD_W'(pos + stride);
            end
            else
            begin
                s.slab_min_y = asp_pkg::COORD_W'(pos);
                s.slab_max_y = asp_pkg::COORD_W'(pos + stride);
            end
            pos         = pos + stride;
            s.cut_axis  = on_z;
            s.empty_res = 1'b0;
            s.last      = (i == cnt - 1);
            add_due(s);
        end
    endfunction

    function automatic string slab_diff(asp_pkg::slab_t e, asp_pkg::slab_t a);
        string d;
        d = "";
        if (e.slab_index != a.slab_index) d = {d, " slab_index"};
        if (e.slab_total != a.slab_total) d = {d, " slab_total"};
        if (e.slab_min_x != a.slab_min_x) d = {d, " slab_min_x"};
        if (e.slab_min_y != a.slab_min_y) d = {d, " slab_min_y"};
        if (e.slab_min_z != a.slab_min_z) d = {d, " slab_min_z"};
        if (e.slab_max_x != a.slab_max_x) d = {d, " slab_max_x"};
        if (e.slab_max_y != a.slab_max_y) d = {d, " slab_max_y"};
        if (e.slab_max_z != a.slab_max_z) d = {d, " slab_max_z"};
        if (e.cut_axis   != a.cut_axis)   d = {d, " cut_axis"};
        if (e.empty_res  != a.empty_res)  d = {d, " empty_res"};
        if (e.last       != a.last)       d = {d, " last"};
        return d;
    endfunction

    function automatic void note_mismatch(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("MISMATCH %0t: %s", $time, msg);
    endfunction

    function automatic asp_pkg::box_t mk_box(int mnx, int mny, int mnz,
                                             int mxx, int mxy, int mxz);
        asp_pkg::box_t b;
        b.box_min_x = asp_pkg::COORD_W'(mnx);
        b.box_min_y = asp_pkg::COORD_W'(mny);
        b.box_min_z = asp_pkg::COORD_W'(mnz);
        b.box_max_x = asp_pkg::COORD_W'(mxx);
        b.box_max_y = asp_pkg::COORD_W'(mxy);
        b.box_max_z = asp_pkg::COORD_W'(mxz);
        return b;
    endfunction

    function automatic int pick_extent(int w);
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 1;
            2: return $urandom_range(1, w);
            3: return w;
            4: return $urandom_range(w, 3 * w + 5);
            default: return $urandom_range(0, 32767);
        endcase
    endfunction

    function automatic asp_pkg::box_t rand_box();
        asp_pkg::box_t b;
        logic [95:0]   raw;
        int            ey;
        int            ez;
        int            lo;
        raw = {$urandom, $urandom, $urandom};
        b   = raw[$bits(asp_pkg::box_t)-1:0];
        if ($urandom_range(0, 99) < 12)
            return b;
        ey = pick_extent(workers());
        ez = pick_extent(workers());
        lo = $urandom_range(0, 32767 - ey);
        b.box_min_y = asp_pkg::COORD_W'(lo);
        b.box_max_y = asp_pkg::COORD_W'(lo + ey);
        lo = $urandom_range(0, 32767 - ez);
        b.box_min_z = asp_pkg::COORD_W'(lo);
        b.box_max_z = asp_pkg::COORD_W'(lo + ez);
        return b;
    endfunction

    task automatic reg_write(logic idx, logic [6:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= asp_pkg::PDATA_W'(val);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == asp_pkg::REG_WORK_NODES)
            cfg_nodes = val;
        else
            cfg_threads = val;
    endtask

    task automatic drain();
        do
            @(negedge clk);
        while (box_backlog.size() != 0 || start || slabs_due.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    // driver: hold start until the beat is taken, then advance
    always @(posedge clk)
    begin : drive
        logic          go;
        asp_pkg::box_t nxt;
        go  = start;
        nxt = box;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                plan_slabs(box);
                boxes_sent++;
                go = 1'b0;
            end
            if (!go && box_backlog.size() != 0 &&
                (free_run || $urandom_range(0, 99) >= 29))
            begin
                nxt = box_backlog.pop_front();
                go  = 1'b1;
            end
        end
        start <= go;
        box   <= nxt;
    end

    always @(posedge clk)
    begin : watch
        asp_pkg::slab_t e;
        string          d;
        if (rst_n && result_valid)
        begin
            beats_seen++;
            if (slabs_due.size() == 0)
                note_mismatch($sformatf("unexpected beat %h", result));
            else
            begin
                e = slabs_due.pop_front();
                d = slab_diff(e, result);
                if (d != "")
                    note_mismatch($sformatf("fields%s: exp %h got %h", d, e, result));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid || (psel && penable))
            quiet <= 0;
        else if (quiet >= QUIET_LIMIT)
        begin
            $display("watchdog expired with %0d beats outstanding", slabs_due.size());
            $display("axis_slab_partitioner_top test failed");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    initial
    begin : stimulus
        int node_set[PHASES]   = '{1, 64, 127, 5, 3, 8, 0, 2, 0};
        int thread_set[PHASES] = '{64, 1, 127, 0, 7, 8, 127, 2, 0};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        repeat (20) enqueue_box(rand_box());
        drain();

        reg_write(asp_pkg::REG_WORK_NODES, 7'd2);
        reg_write(asp_pkg::REG_THREADS, 7'd3);
        settings++;
        enqueue_box(mk_box(5, 40, 9, 50, 40, 9));
        enqueue_box(mk_box(0, 0, 0, 0, 0, 0));
        enqueue_box(mk_box(32767, 32767, 32767, 32767, 32767, 32767));
        enqueue_box(mk_box(1, 2, 3, 4, 12, 4));
        enqueue_box(mk_box(1, 2, 3, 4, 5, 4));
        enqueue_box(mk_box(1, 2, 3, 4, 8, 4));
        enqueue_box(mk_box(1, 2, 3, 4, 15, 7));
        enqueue_box(mk_box(1, 2, 3, 4, 5, 9));
        enqueue_box(mk_box(1, 2, 3, 4, 5, 23));
        enqueue_box(mk_box(7, 100, 0, 7, 50, 0));
        enqueue_box(mk_box(7, 10, 200, 9, 17, 10));
        enqueue_box(mk_box(7, 300, 50, 9, 0, 56));
        enqueue_box(mk_box(0, 0, 0, 32767, 32767, 32767));
        enqueue_box(mk_box(32767, 0, 100, 0, 32767, 101));
        enqueue_box(mk_box(21845, 0, 10922, 10922, 32767, 10924));
        enqueue_box(mk_box(1, 1, 1, 33, 17, 9));
        enqueue_box(mk_box(0, 32760, 32761, 32767, 32767, 32767));
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            if (p == PHASES - 1)
            begin
                node_set[p]   = $urandom_range(0, 127);
                thread_set[p] = $urandom_range(0, 127);
            end
            reg_write(asp_pkg::REG_WORK_NODES, 7'(node_set[p]));
            reg_write(asp_pkg::REG_THREADS, 7'(thread_set[p]));
            settings++;
            free_run = (p == 4);
            repeat (23) enqueue_box(rand_box());
            drain();
        end
        free_run = 1'b0;

        repeat (SETTLE_TICKS) @(posedge clk);
        if (slabs_due.size() != 0)
            note_mismatch($sformatf("%0d beats never arrived", slabs_due.size()));
        $display("%0d boxes sent, %0d slab beats checked, %0d worker settings",
                 boxes_sent, beats_seen, settings);
        $display("mismatches: %0d", mismatches);
        if (mismatches == 0)
            $display("axis_slab_partitioner_top test passed");
        else
            $display("axis_slab_partitioner_top test failed");
        $finish;
    end

endmodule
